// ===== hdl/double_step_line_rasterizer_core_macros.svh =====
// assertion macros for the double-step line rasterizer
`ifndef DOUBLE_STEP_LINE_RASTERIZER_CORE_MACROS_SVH
`define DOUBLE_STEP_LINE_RASTERIZER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DSLR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that a property holds in the cycle after its condition
`define DSLR_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/dslr_pkg.sv =====
// package: shared types and constants of the line rasterizer
`default_nettype none
package dslr_pkg;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned GroupMax = 4;
  localparam int unsigned OutDepth = 8;

  typedef enum logic [0:0] {
    ActStart = 1'b0,
    ActStep  = 1'b1
  } action_e;
endpackage
`default_nettype wire

// ===== hdl/dslr_front.sv =====
// front end: decodes items, sets up lines from endpoints into a queue word
`default_nettype none
module dslr_front #(
  parameter int unsigned CoordBits = dslr_pkg::CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic                        action_i,
  input  wire logic signed [CoordBits-1:0] start_x_i,
  input  wire logic signed [CoordBits-1:0] start_y_i,
  input  wire logic signed [CoordBits-1:0] end_x_i,
  input  wire logic signed [CoordBits-1:0] end_y_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic                             action_o,
  output logic                             span_o,
  output logic                             swap_o,
  output logic                             neg_o,
  output logic signed [CoordBits-1:0]      fmaj_o,
  output logic signed [CoordBits-1:0]      fmin_o,
  output logic signed [CoordBits-1:0]      bmaj_o,
  output logic signed [CoordBits-1:0]      bmin_o,
  output logic [CoordBits:0]               dx_o,
  output logic [CoordBits:0]               dy_o
);
  import dslr_pkg::*;
  localparam int unsigned W = CoordBits + 1;

  logic valid_q;
  logic action_q, span_q, swap_q, neg_q;
  logic signed [CoordBits-1:0] fmaj_q, fmin_q, bmaj_q, bmin_q;
  logic [W-1:0] dx_q, dy_q;

  logic signed [W-1:0] ddx, ddy;
  logic [W-1:0] adx, ady;
  logic nx, ny, steep, ex, ey, flip;
  logic signed [CoordBits-1:0] a1, b1, a2, b2;
  logic span_d, swap_d, neg_d;
  logic signed [CoordBits-1:0] fmaj_d, fmin_d, bmaj_d, bmin_d;
  logic [W-1:0] dx_d, dy_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ex = (start_x_i == end_x_i);
    ey = (start_y_i == end_y_i);
    ddx = W'(end_x_i) - W'(start_x_i);
    ddy = W'(end_y_i) - W'(start_y_i);
    nx = ddx[W-1];
    ny = ddy[W-1];
    adx = nx ? W'(-ddx) : W'(ddx);
    ady = ny ? W'(-ddy) : W'(ddy);
    steep = ady > adx;
    a1 = steep ? start_y_i : start_x_i;
    b1 = steep ? start_x_i : start_y_i;
    a2 = steep ? end_y_i : end_x_i;
    b2 = steep ? end_x_i : end_y_i;
    flip = a1 > a2;
    span_d = ex || ey;
    neg_d = nx ^ ny;
    dx_d = steep ? ady : adx;
    dy_d = steep ? adx : ady;
    if (span_d) begin
      swap_d = ex;
      fmin_d = ex ? start_x_i : start_y_i;
      bmin_d = fmin_d;
      if (ex) begin
        fmaj_d = (start_y_i < end_y_i) ? start_y_i : end_y_i;
        bmaj_d = (start_y_i < end_y_i) ? end_y_i : start_y_i;
      end else begin
        fmaj_d = (start_x_i < end_x_i) ? start_x_i : end_x_i;
        bmaj_d = (start_x_i < end_x_i) ? end_x_i : start_x_i;
      end
    end else begin
      swap_d = steep;
      fmaj_d = flip ? a2 : a1;
      fmin_d = flip ? b2 : b1;
      bmaj_d = flip ? a1 : a2;
      bmin_d = flip ? b1 : b2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      action_q <= action_i;
      span_q <= span_d;
      swap_q <= swap_d;
      neg_q <= neg_d;
      fmaj_q <= fmaj_d;
      fmin_q <= fmin_d;
      bmaj_q <= bmaj_d;
      bmin_q <= bmin_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign valid_o = valid_q;
  assign action_o = action_q;
  assign span_o = span_q;
  assign swap_o = swap_q;
  assign neg_o = neg_q;
  assign fmaj_o = fmaj_q;
  assign fmin_o = fmin_q;
  assign bmaj_o = bmaj_q;
  assign bmin_o = bmin_q;
  assign dx_o = dx_q;
  assign dy_o = dy_q;
endmodule
`default_nettype wire

// ===== hdl/dslr_back.sv =====
// back end: line state and pixel group generation into an output queue
`default_nettype none
module dslr_back #(
  parameter int unsigned CoordBits = dslr_pkg::CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic                        action_i,
  input  wire logic                        span_i,
  input  wire logic                        swap_i,
  input  wire logic                        neg_i,
  input  wire logic signed [CoordBits-1:0] fmaj_i,
  input  wire logic signed [CoordBits-1:0] fmin_i,
  input  wire logic signed [CoordBits-1:0] bmaj_i,
  input  wire logic signed [CoordBits-1:0] bmin_i,
  input  wire logic [CoordBits:0]          dx_i,
  input  wire logic [CoordBits:0]          dy_i,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic signed [CoordBits-1:0]      pixel_x_o,
  output logic signed [CoordBits-1:0]      pixel_y_o,
  output logic                             line_done_o,
  output logic                             group_last_o
);
  import dslr_pkg::*;
  `include "double_step_line_rasterizer_core_macros.svh"

  localparam int unsigned EW = CoordBits + 5;
  localparam int unsigned PW = 2 * CoordBits + 2;
  localparam int unsigned AW = $clog2(OutDepth);

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeSpan = 4'b0010,
    ModeLow  = 4'b0100,
    ModeHigh = 4'b1000
  } mode_e;

  mode_e mode_q, mode_d;
  logic signed [CoordBits-1:0] fmaj_q, fmaj_d, fmin_q, fmin_d;
  logic signed [CoordBits-1:0] bmaj_q, bmaj_d, bmin_q, bmin_d;
  logic signed [EW-1:0] err_q, err_d, inc1_q, inc1_d, inc2_q, inc2_d, bnd_q, bnd_d;
  logic neg_q, neg_d, swap_q, swap_d, pend_q, pend_d;
  logic [CoordBits-2:0] iter_q, iter_d;
  logic [1:0] left_q, left_d;

  logic [PW-1:0] mem_q [OutDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q, cnt_d;

  logic [PW-1:0] px [GroupMax];
  logic [2:0] n;
  logic done;
  logic take;
  logic signed [CoordBits-1:0] s;
  logic [2:0] pat;
  logic stf, stb;
  logic signed [CoordBits-1:0] mj [GroupMax];
  logic signed [CoordBits-1:0] mn [GroupMax];
  logic signed [EW-1:0] edx, edy, i2;
  logic [CoordBits:0] dm1;
  logic pop_ok;

  assign ready_o = (cnt_q <= (AW+1)'(OutDepth - GroupMax));
  assign take = valid_i && ready_o;
  assign pop_ok = pop_i && !empty_o;

  always_comb begin
    mode_d = mode_q; fmaj_d = fmaj_q; fmin_d = fmin_q; bmaj_d = bmaj_q;
    bmin_d = bmin_q; err_d = err_q; inc1_d = inc1_q; inc2_d = inc2_q;
    bnd_d = bnd_q; neg_d = neg_q; swap_d = swap_q; pend_d = pend_q;
    iter_d = iter_q; left_d = left_q;
    n = 3'd0; done = 1'b0; pat = 3'd1; stf = 1'b0; stb = 1'b0;
    s = neg_q ? -CoordBits'(1) : CoordBits'(1);
    edx = EW'(dx_i); edy = EW'(dy_i);
    i2 = (edy <<< 2) - (edx <<< 1);
    dm1 = dx_i - (CoordBits+1)'(1);
    for (int k = 0; k < GroupMax; k++) begin
      mj[k] = fmaj_q; mn[k] = fmin_q;
    end
    if (mode_q == ModeLow) begin
      pat = err_q < 0 ? 3'd1 : (err_q < bnd_q ? 3'd2 : 3'd3);
    end else begin
      pat = err_q > 0 ? 3'd4 : (err_q < bnd_q ? 3'd2 : 3'd3);
    end
    stf = (pat == 3'd3) || (pat == 3'd4);
    stb = (pat == 3'd2) || (pat == 3'd4);
    if (take && action_i == ActStart) begin
      neg_d = 1'b0; swap_d = swap_i; pend_d = 1'b0;
      iter_d = '0; left_d = '0; err_d = '0; inc1_d = '0; inc2_d = '0; bnd_d = '0;
      fmaj_d = fmaj_i; fmin_d = fmin_i; bmaj_d = bmaj_i;
      if (span_i) begin
        mode_d = ModeSpan; bmin_d = '0;
      end else begin
        bmin_d = bmin_i; neg_d = neg_i; pend_d = 1'b1;
        iter_d = dm1[CoordBits:2];
        left_d = dm1[1:0];
        inc2_d = i2;
        if (i2 < 0) begin
          mode_d = ModeLow; bnd_d = edy <<< 1; inc1_d = edy <<< 2;
          err_d = (edy <<< 2) - edx;
        end else begin
          mode_d = ModeHigh; bnd_d = (edy - edx) <<< 1;
          inc1_d = (edy - edx) <<< 2; err_d = ((edy - edx) <<< 2) + edx;
        end
      end
    end else if (take && mode_q == ModeSpan) begin
      for (int k = 0; k < GroupMax; k++) begin
        mj[k] = fmaj_q + CoordBits'(k);
      end
      if (((bmaj_q - fmaj_q) < CoordBits'(GroupMax) && !(bmaj_q < fmaj_q))
          || (bmaj_q <= fmaj_q)) begin
        n = (bmaj_q <= fmaj_q) ? 3'd1 : 3'(bmaj_q - fmaj_q + 1);
        done = 1'b1;
      end else begin
        n = 3'd4;
        fmaj_d = fmaj_q + CoordBits'(GroupMax);
      end
    end else if (take && mode_q != ModeIdle) begin
      if (pend_q) begin
        mj[1] = bmaj_q; mn[1] = bmin_q; n = 3'd2; pend_d = 1'b0;
        done = (iter_q == '0) && (left_q == '0);
      end else if (iter_q != '0) begin
        mj[0] = fmaj_q + CoordBits'(1); mn[0] = stf ? fmin_q + s : fmin_q;
        mj[1] = fmaj_q + CoordBits'(2); mn[1] = stb ? mn[0] + s : mn[0];
        mj[2] = bmaj_q - CoordBits'(1); mn[2] = stf ? bmin_q - s : bmin_q;
        mj[3] = bmaj_q - CoordBits'(2); mn[3] = stb ? mn[2] - s : mn[2];
        n = 3'd4;
        fmaj_d = mj[1]; fmin_d = mn[1]; bmaj_d = mj[3]; bmin_d = mn[3];
        err_d = err_q + (((pat == 3'd1) || (pat == 3'd4)) ? inc1_q : inc2_q);
        iter_d = iter_q - (CoordBits-1)'(1);
        done = (iter_d == '0) && (left_q == '0);
      end else begin
        mj[0] = fmaj_q + CoordBits'(1); mn[0] = stf ? fmin_q + s : fmin_q;
        mj[1] = fmaj_q + CoordBits'(2); mn[1] = stb ? mn[0] + s : mn[0];
        mj[2] = bmaj_q - CoordBits'(1);
        mn[2] = (pat == 3'd4 || (pat == 3'd3 && (mode_q == ModeLow || err_q > bnd_q)))
                ? bmin_q - s : bmin_q;
        n = 3'(left_q);
        left_d = '0;
        done = 1'b1;
      end
    end
    if (done) mode_d = ModeIdle;
    for (int k = 0; k < GroupMax; k++) begin
      px[k] = swap_q ? {mn[k], mj[k], (3'(k) + 3'd1 == n) && done, 3'(k) + 3'd1 == n}
                     : {mj[k], mn[k], (3'(k) + 3'd1 == n) && done, 3'(k) + 3'd1 == n};
    end
    cnt_d = cnt_q + (AW+1)'(n) - (AW+1)'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; fmaj_q <= '0; fmin_q <= '0; bmaj_q <= '0; bmin_q <= '0;
      err_q <= '0; inc1_q <= '0; inc2_q <= '0; bnd_q <= '0; neg_q <= 1'b0;
      swap_q <= 1'b0; pend_q <= 1'b0; iter_q <= '0; left_q <= '0;
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      mode_q <= mode_d; fmaj_q <= fmaj_d; fmin_q <= fmin_d; bmaj_q <= bmaj_d;
      bmin_q <= bmin_d; err_q <= err_d; inc1_q <= inc1_d; inc2_q <= inc2_d;
      bnd_q <= bnd_d; neg_q <= neg_d; swap_q <= swap_d; pend_q <= pend_d;
      iter_q <= iter_d; left_q <= left_d;
      wp_q <= wp_q + AW'(n);
      rp_q <= rp_q + AW'(pop_ok);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < GroupMax; k++) begin
      if (3'(k) < n) mem_q[wp_q + AW'(k)] <= px[k];
    end
  end

  assign empty_o = (cnt_q == '0);
  assign pixel_x_o = mem_q[rp_q][PW-1 -: CoordBits];
  assign pixel_y_o = mem_q[rp_q][PW-1-CoordBits -: CoordBits];
  assign line_done_o = mem_q[rp_q][1];
  assign group_last_o = mem_q[rp_q][0];

  `DSLR_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (AW+1)'(OutDepth), "queue overflow")
  `DSLR_ASSERT(a_done_last, clk_i, rst_ni, !empty_o && line_done_o |-> group_last_o,
               "line end not group end")
  `DSLR_ASSERT_NEXT(a_idle_done, clk_i, rst_ni, done,
                    mode_q == ModeIdle || $past(take && action_i == ActStart),
                    "mode not idle after line end")
endmodule
`default_nettype wire

// ===== hdl/double_step_line_rasterizer_core.sv =====
// top level: double-step line rasterizer with decoupled setup and drawing
// usage:
//   input queue: push with action_i and endpoints, accepted when full low
//   action 0 loads a line (no pixels), action 1 asks for the next pixel group
//   result queue: pixel words are on the ports while empty is low, pop
//   takes the oldest; group_last_o ends a group, line_done_o ends a line
//   path: a pushed item passes the setup register, then the drawing stage
//   writes its group into the pixel queue, where it becomes readable
//   throughput: one item per cycle while the 8-word pixel queue has room
//   for a whole group of four; the drawing loop is one iteration per cycle
//   a stalled reader fills the pixel queue, then full rises; nothing lost
//   reset clears both stages and the queue, no line is active after reset
`default_nettype none
module double_step_line_rasterizer_core #(
  parameter int unsigned CoordBits = dslr_pkg::CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        action_i,
  input  wire logic signed [CoordBits-1:0] start_x_i,
  input  wire logic signed [CoordBits-1:0] start_y_i,
  input  wire logic signed [CoordBits-1:0] end_x_i,
  input  wire logic signed [CoordBits-1:0] end_y_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [CoordBits-1:0]      pixel_x_o,
  output logic signed [CoordBits-1:0]      pixel_y_o,
  output logic                             line_done_o,
  output logic                             group_last_o
);
  import dslr_pkg::*;

  logic fr_ready, q_valid, q_ready, q_action, q_span, q_swap, q_neg;
  logic signed [CoordBits-1:0] q_fmaj, q_fmin, q_bmaj, q_bmin;
  logic [CoordBits:0] q_dx, q_dy;

  assign full = !fr_ready;

  dslr_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .valid_i(push), .ready_o(fr_ready), .action_i,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .valid_o(q_valid), .ready_i(q_ready), .action_o(q_action), .span_o(q_span),
    .swap_o(q_swap), .neg_o(q_neg), .fmaj_o(q_fmaj), .fmin_o(q_fmin),
    .bmaj_o(q_bmaj), .bmin_o(q_bmin), .dx_o(q_dx), .dy_o(q_dy)
  );

  dslr_back #(.CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ready_o(q_ready), .action_i(q_action),
    .span_i(q_span), .swap_i(q_swap), .neg_i(q_neg), .fmaj_i(q_fmaj),
    .fmin_i(q_fmin), .bmaj_i(q_bmaj), .bmin_i(q_bmin), .dx_i(q_dx), .dy_i(q_dy),
    .empty_o(empty), .pop_i(pop), .pixel_x_o, .pixel_y_o, .line_done_o,
    .group_last_o
  );
endmodule
`default_nettype wire

// ===== verif/double_step_line_rasterizer_core_tb.sv =====
// testbench of the double-step line rasterizer: directed and random lines checked pixel by pixel
module double_step_line_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dslr_pkg::*;

  localparam int CB = CoordBitsDef;

  typedef enum int {DrawIdle, DrawSpan, DrawLow, DrawHigh} draw_e;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          done;
    logic          last;
  } pixel_t;

  logic clk_i, rst_ni, push, full, empty, pop;
  action_e action_i;
  logic signed [CB-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic signed [CB-1:0] pixel_x_o, pixel_y_o;
  logic line_done_o, group_last_o;

  double_step_line_rasterizer_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .action_i(action_i),
    .start_x_i(start_x_i), .start_y_i(start_y_i), .end_x_i(end_x_i), .end_y_i(end_y_i),
    .empty(empty), .pop(pop), .pixel_x_o(pixel_x_o), .pixel_y_o(pixel_y_o),
    .line_done_o(line_done_o), .group_last_o(group_last_o)
  );

  // predictor state
  draw_e mode;
  int f_maj, f_min, b_maj, b_min, err, inc1, inc2, bound;
  bit neg, swapped, pend;
  int iters, left;

  pixel_t pixel_q[$];
  pixel_t grp[$];
  int items_sent, pixels_seen, mismatches, lines_drawn;
  int hold_cycles, rx_gap;
  bit rx_fast, tx_fast;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic int sx(logic [CB-1:0] v);
    return int'($signed(v));
  endfunction

  task automatic clear_state();
    mode = DrawIdle;
    f_maj = 0; f_min = 0; b_maj = 0; b_min = 0;
    err = 0; inc1 = 0; inc2 = 0; bound = 0;
    neg = 0; swapped = 0; pend = 0; iters = 0; left = 0;
  endtask

  task automatic put_pixel(int maj, int mnr);
    pixel_t p;
    int px, py;
    px = swapped ? mnr : maj;
    py = swapped ? maj : mnr;
    p.x = px[CB-1:0];
    p.y = py[CB-1:0];
    p.done = 0;
    p.last = 0;
    grp.push_back(p);
  endtask

  function automatic int pattern();
    if (mode == DrawLow) begin
      if (err < 0) return 1;
      return (err < bound) ? 2 : 3;
    end
    if (err > 0) return 4;
    return (err < bound) ? 2 : 3;
  endfunction

  task automatic setup_line(logic [CB-1:0] ax, logic [CB-1:0] ay,
                            logic [CB-1:0] bx, logic [CB-1:0] by);
    int a1, b1, a2, b2, dx, dy, t;
    bit nx, ny;
    a1 = sx(ax); b1 = sx(ay); a2 = sx(bx); b2 = sx(by);
    clear_state();
    if (a1 == a2 || b1 == b2) begin
      mode = DrawSpan;
      if (a1 == a2) begin
        swapped = 1;
        f_min = a1;
        f_maj = b1 < b2 ? b1 : b2;
        b_maj = b1 < b2 ? b2 : b1;
      end else begin
        f_min = b1;
        f_maj = a1 < a2 ? a1 : a2;
        b_maj = a1 < a2 ? a2 : a1;
      end
      return;
    end
    dx = a2 - a1; dy = b2 - b1;
    nx = dx < 0; ny = dy < 0;
    if (nx) dx = -dx;
    if (ny) dy = -dy;
    neg = nx != ny;
    if (dy > dx) begin
      t = a1; a1 = b1; b1 = t;
      t = a2; a2 = b2; b2 = t;
      t = dx; dx = dy; dy = t;
      swapped = 1;
    end
    if (a1 > a2) begin
      f_maj = a2; f_min = b2; b_maj = a1; b_min = b1;
    end else begin
      f_maj = a1; f_min = b1; b_maj = a2; b_min = b2;
    end
    iters = (dx - 1) / 4;
    left = (dx - 1) % 4;
    inc2 = 4 * dy - 2 * dx;
    if (inc2 < 0) begin
      mode = DrawLow;
      bound = 2 * dy;
      inc1 = 2 * bound;
      err = inc1 - dx;
    end else begin
      mode = DrawHigh;
      bound = 2 * (dy - dx);
      inc1 = 2 * bound;
      err = inc1 + dx;
    end
    pend = 1;
  endtask

  task automatic predict_word(action_e a, logic [CB-1:0] ax, logic [CB-1:0] ay,
                              logic [CB-1:0] bx, logic [CB-1:0] by);
    bit done;
    int s, p;
    done = 0;
    grp.delete();
    if (a == ActStart) begin
      setup_line(ax, ay, bx, by);
      return;
    end
    if (mode == DrawIdle) return;
    if (mode == DrawSpan) begin
      while (grp.size() < 4 && !done) begin
        put_pixel(f_maj, f_min);
        if (f_maj >= b_maj) done = 1;
        else f_maj++;
      end
    end else begin
      s = neg ? -1 : 1;
      if (pend) begin
        put_pixel(f_maj, f_min);
        put_pixel(b_maj, b_min);
        pend = 0;
      end else if (iters > 0) begin
        p = pattern();
        f_maj++;
        b_maj--;
        if (p == 3 || p == 4) f_min += s;
        put_pixel(f_maj, f_min);
        f_maj++;
        if (p == 2 || p == 4) f_min += s;
        put_pixel(f_maj, f_min);
        if (p == 3 || p == 4) b_min -= s;
        put_pixel(b_maj, b_min);
        b_maj--;
        if (p == 2 || p == 4) b_min -= s;
        put_pixel(b_maj, b_min);
        err += (p == 1 || p == 4) ? inc1 : inc2;
        iters--;
      end else if (left > 0) begin
        p = pattern();
        f_maj++;
        if (p == 3 || p == 4) f_min += s;
        put_pixel(f_maj, f_min);
        if (left > 1) begin
          f_maj++;
          if (p == 2 || p == 4) f_min += s;
          put_pixel(f_maj, f_min);
        end
        if (left > 2) begin
          b_maj--;
          if (p == 4 || (p == 3 && (mode == DrawLow || err > bound))) b_min -= s;
          put_pixel(b_maj, b_min);
        end
        left = 0;
      end
      if (!pend && iters == 0 && left == 0) done = 1;
    end
    if (grp.size() > 0) begin
      grp[grp.size()-1].last = 1;
      if (done) grp[grp.size()-1].done = 1;
    end
    if (done) begin
      mode = DrawIdle;
      lines_drawn++;
    end
    foreach (grp[i]) pixel_q.push_back(grp[i]);
  endtask

  // sender: always called and left at a falling edge
  task automatic send_word(action_e a, logic [CB-1:0] ax, logic [CB-1:0] ay,
                           logic [CB-1:0] bx, logic [CB-1:0] by);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(16);
    if (gap > 0) begin
      push = 0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1;
    action_i = a;
    start_x_i = ax; start_y_i = ay; end_x_i = bx; end_y_i = by;
    do @(posedge clk_i); while (full);
    predict_word(a, ax, ay, bx, by);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic step_word();
    send_word(ActStep, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  task automatic draw_line(int ax, int ay, int bx, int by, int max_steps);
    int n;
    send_word(ActStart, ax[CB-1:0], ay[CB-1:0], bx[CB-1:0], by[CB-1:0]);
    n = 0;
    while (mode != DrawIdle && n < max_steps) begin
      step_word();
      n++;
    end
  endtask

  task automatic drain();
    push = 0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // receiver and checker
  initial begin
    pop = 0;
    rx_gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word x=%0d y=%0d", pixel_x_o, pixel_y_o);
        end else begin
          pixel_t e;
          e = pixel_q.pop_front();
          if (e.x !== pixel_x_o || e.y !== pixel_y_o || e.done !== line_done_o ||
              e.last !== group_last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp x=%0d y=%0d done=%0b last=%0b, ",
                        "got x=%0d y=%0d done=%0b last=%0b"},
                       $signed(e.x), $signed(e.y), e.done, e.last,
                       pixel_x_o, pixel_y_o, line_done_o, group_last_o);
          end
        end
        rx_gap = rx_fast ? 0 : $urandom_range(16);
      end
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop = 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop = 0;
      end else begin
        pop = 1;
      end
    end
  end

  task automatic test_directed();
    step_word();                             // step before any line
    draw_line(5, 5, 5, 5, 4);                // single point
    step_word();                             // step after the final pixel
    draw_line(0, 0, 1, 1, 4);                // two-pixel line
    draw_line(9, -3, 2, -3, 8);              // horizontal span, reversed
    draw_line(-7, 4, -7, -4, 8);             // vertical span
    draw_line(0, 0, 13, 3, 8);               // shallow
    draw_line(3, 2, -1, -12, 8);             // steep, negative
    draw_line(-2048, -2048, 2047, 2047, 2);  // extremes, abandoned
    draw_line(2047, -2048, -2048, 2047, 2);
    draw_line(-2048, 100, 2047, 100, 1);
    draw_line(10, 0, 0, 6, 8);               // slope one half region
    drain();
  endtask

  task automatic test_random(int target);
    int ax, ay, bx, by, r;
    while (items_sent < target) begin
      tx_fast = ($urandom_range(5) == 0);
      rx_fast = ($urandom_range(5) == 0);
      r = $urandom_range(19);
      ax = sx(CB'($urandom));
      ay = sx(CB'($urandom));
      if (r == 0) begin
        send_word(action_e'($urandom_range(1)), CB'($urandom), CB'($urandom),
                  CB'($urandom), CB'($urandom));
      end else if (r == 1) begin
        draw_line(ax, ay, sx(CB'($urandom)), sx(CB'($urandom)), $urandom_range(3));
      end else begin
        if (r == 2) begin
          bx = ax; by = ay + $urandom_range(20) - 10;
        end else if (r == 3) begin
          by = ay; bx = ax + $urandom_range(20) - 10;
        end else begin
          bx = ax + $urandom_range(60) - 30;
          by = ay + $urandom_range(60) - 30;
        end
        draw_line(ax, ay, bx, by, (r == 4) ? $urandom_range(3) : 1000);
        if ($urandom_range(3) == 0) step_word();
      end
    end
    tx_fast = 0;
    rx_fast = 0;
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    tx_fast = 1;
    draw_line(0, 0, 90, 37, 40);
    tx_fast = 0;
    drain();
    draw_line(-50, 20, 30, -9, 3);
    drain();
  endtask

  initial begin
    push = 0;
    action_i = ActStep;
    start_x_i = 0; start_y_i = 0; end_x_i = 0; end_y_i = 0;
    rst_ni = 0;
    items_sent = 0; pixels_seen = 0; mismatches = 0; lines_drawn = 0;
    hold_cycles = 0; rx_fast = 0; tx_fast = 0;
    clear_state();
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(430);
    if (pixel_q.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", pixel_q.size());
    end
    $display("sent %0d items, checked %0d pixel words over %0d finished lines",
             items_sent, pixels_seen, lines_drawn);
    $display("spans, shallow and steep lines, abandoned lines and idle steps; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
